// ===== hdl/mutex_condvar_lock_manager_core_assert.svh =====
// Assertion macros for the lock manager core
`ifndef MUTEX_CONDVAR_LOCK_MANAGER_CORE_ASSERT_SVH
`define MUTEX_CONDVAR_LOCK_MANAGER_CORE_ASSERT_SVH

// same-cycle implication
`define MCLM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lock manager check failed");

// next-cycle implication
`define MCLM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lock manager check failed");

`endif

// ===== hdl/mclm_pkg.sv =====
`default_nettype none
package mclm_pkg;

  localparam int unsigned PROCESS_COUNT   = 32;
  localparam int unsigned MUTEX_SLOTS     = 16;
  localparam int unsigned CONDITION_SLOTS = 16;

  localparam int unsigned PID_W  = 15;
  localparam int unsigned ID_W   = 31;
  localparam int unsigned RING_W = $clog2(PROCESS_COUNT);
  localparam int unsigned WCNT_W = $clog2(PROCESS_COUNT + 1);
  localparam int unsigned MIDX_W = (MUTEX_SLOTS > 1) ? $clog2(MUTEX_SLOTS) : 1;
  localparam int unsigned MCNT_W = $clog2(MUTEX_SLOTS + 1);
  localparam int unsigned CIDX_W = (CONDITION_SLOTS > 1) ? $clog2(CONDITION_SLOTS) : 1;
  localparam int unsigned CCNT_W = $clog2(CONDITION_SLOTS + 1);
  localparam int unsigned MRING_AW = MIDX_W + RING_W;
  localparam int unsigned CWAIT_AW = CIDX_W + RING_W;
  localparam int unsigned CWAIT_W  = PID_W + ID_W;

  localparam logic [PID_W:0] OWNER_FREE = {1'b1, {PID_W{1'b0}}};
  localparam logic [ID_W:0]  COND_FREE  = {1'b1, {ID_W{1'b0}}};

  typedef enum logic [1:0] {
    CMD_LOCK   = 2'd0,
    CMD_UNLOCK = 2'd1,
    CMD_WAIT   = 2'd2,
    CMD_BCAST  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BUSY      = 3'd1,
    ST_NOT_OWNER = 3'd2,
    ST_INVALID   = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic {
    KIND_REPLY = 1'b0,
    KIND_WAKE  = 1'b1
  } kind_e;

  typedef enum logic [4:0] {
    S_IDLE, S_L_FIND, S_L_EVAL, S_L_FREE, S_L_RET,
    S_F_FIND, S_F_EVAL, S_REL, S_REL_WAKE,
    S_C_FIND, S_C_FREE, S_C_CHECK, S_C_COMMIT,
    S_B_SCAN, S_B_RD, S_B_LD, S_B_WAKE, S_REPLY
  } state_e;

  typedef struct packed {
    logic [1:0]      command;
    logic [PID_W-1:0] requester;
    logic [ID_W-1:0]  mutex_id;
    logic [ID_W-1:0]  condition_id;
  } in_t;

  typedef struct packed {
    logic             kind;
    logic [2:0]       status;
    logic [PID_W-1:0] target_process;
    logic [ID_W-1:0]  granted_mutex;
    logic             last_result;
  } out_t;

endpackage
`default_nettype wire

// ===== hdl/mclm_ram.sv =====
`default_nettype none
module mclm_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hdl/mutex_condvar_lock_manager_core.sv =====
// One request at a time; the sequencer scans the slot tables one entry per cycle
// and the waiter memories through one registered read port each.
// Reset clears the sequencer, slot counts and output valid; table entries are
// undefined until claimed, so no clearing pass is needed.
`default_nettype none
`include "mutex_condvar_lock_manager_core_assert.svh"
module mutex_condvar_lock_manager_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire mclm_pkg::in_t  in_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output mclm_pkg::out_t      out_o
);

  localparam int unsigned PW = mclm_pkg::PID_W;
  localparam int unsigned IW = mclm_pkg::ID_W;
  localparam int unsigned RW = mclm_pkg::RING_W;

  mclm_pkg::state_e state_q, state_d;
  mclm_pkg::cmd_e   cmd_q, cmd_d;
  mclm_pkg::status_e status_q, status_d, lk_st_q, lk_st_d;
  logic [PW-1:0] pid_q, pid_d, lk_pid_q, lk_pid_d;
  logic [IW-1:0] mid_q, mid_d, cid_q, cid_d, lk_key_q, lk_key_d;
  logic [mclm_pkg::MCNT_W-1:0] mptr_q, mptr_d, m_used_q, m_used_d;
  logic [mclm_pkg::CCNT_W-1:0] cptr_q, cptr_d, c_used_q, c_used_d;
  logic [mclm_pkg::WCNT_W-1:0] j_q, j_d;
  logic fresh_q, fresh_d;
  logic out_valid_q, out_valid_d;
  mclm_pkg::out_t out_q, out_d;

  // slot tables
  logic [IW-1:0] m_key_q   [mclm_pkg::MUTEX_SLOTS];
  logic [PW:0]   m_owner_q [mclm_pkg::MUTEX_SLOTS];
  logic [RW-1:0] m_head_q  [mclm_pkg::MUTEX_SLOTS];
  logic [RW-1:0] m_tail_q  [mclm_pkg::MUTEX_SLOTS];
  logic [IW:0]   c_key_q   [mclm_pkg::CONDITION_SLOTS];
  logic [mclm_pkg::WCNT_W-1:0] c_cnt_q [mclm_pkg::CONDITION_SLOTS];

  logic [mclm_pkg::MIDX_W-1:0] mi;
  logic [mclm_pkg::CIDX_W-1:0] ci;
  logic [IW-1:0] key_rd;
  logic [PW:0]   owner_rd;
  logic [RW-1:0] head_rd, tail_rd, head_nx, tail_nx;
  logic [IW:0]   ckey_rd;
  logic [mclm_pkg::WCNT_W-1:0] ccnt_rd;

  logic key_we, owner_we, head_we, tail_we, ckey_we, ccnt_we;
  logic [IW-1:0] key_wd;
  logic [PW:0]   owner_wd;
  logic [RW-1:0] head_wd, tail_wd;
  logic [IW:0]   ckey_wd;
  logic [mclm_pkg::WCNT_W-1:0] ccnt_wd;

  logic ring_we;
  logic [mclm_pkg::MRING_AW-1:0] ring_waddr, ring_raddr;
  logic [PW-1:0] ring_rdata;
  logic cw_we;
  logic [mclm_pkg::CWAIT_AW-1:0] cw_waddr, cw_raddr;
  logic [RW-1:0] cw_widx;
  logic [mclm_pkg::CWAIT_W-1:0] cw_rdata;

  logic m_hit, c_hit, can_emit;

  assign mi       = mptr_q[mclm_pkg::MIDX_W-1:0];
  assign ci       = cptr_q[mclm_pkg::CIDX_W-1:0];
  assign key_rd   = m_key_q[mi];
  assign owner_rd = m_owner_q[mi];
  assign head_rd  = m_head_q[mi];
  assign tail_rd  = m_tail_q[mi];
  assign ckey_rd  = c_key_q[ci];
  assign ccnt_rd  = c_cnt_q[ci];
  assign head_nx  = (head_rd == RW'(mclm_pkg::PROCESS_COUNT - 1)) ? '0 : head_rd + 1'b1;
  assign tail_nx  = (tail_rd == RW'(mclm_pkg::PROCESS_COUNT - 1)) ? '0 : tail_rd + 1'b1;
  assign m_hit    = mptr_q < m_used_q;
  assign c_hit    = cptr_q < c_used_q;
  assign can_emit = !out_valid_q || out_ready_i;

  assign ring_waddr = {mi, tail_rd};
  assign ring_raddr = {mi, head_rd};
  assign cw_widx    = fresh_q ? '0 : ccnt_rd[RW-1:0];
  assign cw_waddr   = {ci, cw_widx};
  assign cw_raddr   = {ci, j_q[RW-1:0]};

  mclm_ram #(
    .DEPTH (1 << mclm_pkg::MRING_AW),
    .WIDTH (PW)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (lk_pid_q),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  mclm_ram #(
    .DEPTH (1 << mclm_pkg::CWAIT_AW),
    .WIDTH (mclm_pkg::CWAIT_W)
  ) u_cwait_ram (
    .clk_i   (clk_i),
    .we_i    (cw_we),
    .waddr_i (cw_waddr),
    .wdata_i ({pid_q, mid_q}),
    .raddr_i (cw_raddr),
    .rdata_o (cw_rdata)
  );

  assign in_ready_o  = (state_q == mclm_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    status_d = status_q;
    lk_st_d  = lk_st_q;
    pid_d    = pid_q;
    mid_d    = mid_q;
    cid_d    = cid_q;
    lk_pid_d = lk_pid_q;
    lk_key_d = lk_key_q;
    mptr_d   = mptr_q;
    cptr_d   = cptr_q;
    m_used_d = m_used_q;
    c_used_d = c_used_q;
    j_d      = j_q;
    fresh_d  = fresh_q;
    out_d    = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    key_we = 1'b0;  key_wd = lk_key_q;
    owner_we = 1'b0; owner_wd = {1'b0, lk_pid_q};
    head_we = 1'b0; head_wd = '0;
    tail_we = 1'b0; tail_wd = '0;
    ckey_we = 1'b0; ckey_wd = {1'b0, cid_q};
    ccnt_we = 1'b0; ccnt_wd = '0;
    ring_we = 1'b0;
    cw_we   = 1'b0;

    unique case (state_q)
      mclm_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_d    = mclm_pkg::cmd_e'(in_i.command);
          pid_d    = in_i.requester;
          mid_d    = in_i.mutex_id;
          cid_d    = in_i.condition_id;
          lk_pid_d = in_i.requester;
          lk_key_d = in_i.mutex_id;
          status_d = mclm_pkg::ST_OK;
          mptr_d   = '0;
          cptr_d   = '0;
          unique case (mclm_pkg::cmd_e'(in_i.command))
            mclm_pkg::CMD_LOCK:  state_d = mclm_pkg::S_L_FIND;
            mclm_pkg::CMD_BCAST: state_d = mclm_pkg::S_B_SCAN;
            default:             state_d = mclm_pkg::S_F_FIND;
          endcase
        end
      end
      // lock operation, shared by lock requests and broadcast relocks
      mclm_pkg::S_L_FIND: begin
        if (m_hit) begin
          if (key_rd == lk_key_q) begin
            state_d = mclm_pkg::S_L_EVAL;
          end else begin
            mptr_d = mptr_q + 1'b1;
          end
        end else begin
          mptr_d  = '0;
          state_d = mclm_pkg::S_L_FREE;
        end
      end
      mclm_pkg::S_L_EVAL: begin
        if (owner_rd == {1'b0, lk_pid_q}) begin
          lk_st_d = mclm_pkg::ST_OK;
          state_d = mclm_pkg::S_L_RET;
        end else if (owner_rd != mclm_pkg::OWNER_FREE) begin
          if (tail_nx == head_rd) begin
            lk_st_d = mclm_pkg::ST_FULL;
          end else begin
            ring_we = 1'b1;
            tail_we = 1'b1;
            tail_wd = tail_nx;
            lk_st_d = mclm_pkg::ST_BUSY;
          end
          state_d = mclm_pkg::S_L_RET;
        end else begin
          mptr_d  = '0;
          state_d = mclm_pkg::S_L_FREE;
        end
      end
      mclm_pkg::S_L_FREE: begin
        if (m_hit && owner_rd != mclm_pkg::OWNER_FREE) begin
          mptr_d = mptr_q + 1'b1;
        end else if (m_hit || m_used_q < mclm_pkg::MCNT_W'(mclm_pkg::MUTEX_SLOTS)) begin
          // claim: mptr points at the free slot or at the first unused one
          key_we   = 1'b1;
          owner_we = 1'b1;
          head_we  = 1'b1;
          tail_we  = 1'b1;
          if (!m_hit) begin
            m_used_d = m_used_q + 1'b1;
          end
          lk_st_d = mclm_pkg::ST_OK;
          state_d = mclm_pkg::S_L_RET;
        end else begin
          lk_st_d = mclm_pkg::ST_FULL;
          state_d = mclm_pkg::S_L_RET;
        end
      end
      mclm_pkg::S_L_RET: begin
        if (cmd_q == mclm_pkg::CMD_LOCK) begin
          status_d = lk_st_q;
          state_d  = mclm_pkg::S_REPLY;
        end else if (lk_st_q == mclm_pkg::ST_OK) begin
          state_d = mclm_pkg::S_B_WAKE;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = mclm_pkg::S_B_RD;
        end
      end
      mclm_pkg::S_F_FIND: begin
        if (m_hit) begin
          if (key_rd == mid_q) begin
            state_d = mclm_pkg::S_F_EVAL;
          end else begin
            mptr_d = mptr_q + 1'b1;
          end
        end else begin
          status_d = (cmd_q == mclm_pkg::CMD_UNLOCK) ? mclm_pkg::ST_NOT_OWNER
                                                     : mclm_pkg::ST_INVALID;
          state_d  = mclm_pkg::S_REPLY;
        end
      end
      mclm_pkg::S_F_EVAL: begin
        if (owner_rd != {1'b0, pid_q}) begin
          status_d = (cmd_q == mclm_pkg::CMD_UNLOCK) ? mclm_pkg::ST_NOT_OWNER
                                                     : mclm_pkg::ST_INVALID;
          state_d  = mclm_pkg::S_REPLY;
        end else if (cmd_q == mclm_pkg::CMD_UNLOCK) begin
          state_d = mclm_pkg::S_REL;
        end else begin
          cptr_d  = '0;
          state_d = mclm_pkg::S_C_FIND;
        end
      end
      // release: ring read issued here, data valid in S_REL_WAKE
      mclm_pkg::S_REL: begin
        if (head_rd == tail_rd) begin
          owner_we = 1'b1;
          owner_wd = mclm_pkg::OWNER_FREE;
          state_d  = (cmd_q == mclm_pkg::CMD_UNLOCK) ? mclm_pkg::S_REPLY
                                                     : mclm_pkg::S_C_COMMIT;
        end else begin
          state_d = mclm_pkg::S_REL_WAKE;
        end
      end
      mclm_pkg::S_REL_WAKE: begin
        if (can_emit) begin
          owner_we = 1'b1;
          owner_wd = {1'b0, ring_rdata};
          head_we  = 1'b1;
          head_wd  = head_nx;
          out_valid_d          = 1'b1;
          out_d.kind           = mclm_pkg::KIND_WAKE;
          out_d.status         = mclm_pkg::ST_OK;
          out_d.target_process = ring_rdata;
          out_d.granted_mutex  = key_rd;
          out_d.last_result    = 1'b0;
          state_d = (cmd_q == mclm_pkg::CMD_UNLOCK) ? mclm_pkg::S_REPLY
                                                    : mclm_pkg::S_C_COMMIT;
        end
      end
      mclm_pkg::S_C_FIND: begin
        if (c_hit) begin
          if (ckey_rd == {1'b0, cid_q}) begin
            fresh_d = 1'b0;
            state_d = mclm_pkg::S_C_CHECK;
          end else begin
            cptr_d = cptr_q + 1'b1;
          end
        end else begin
          cptr_d  = '0;
          state_d = mclm_pkg::S_C_FREE;
        end
      end
      mclm_pkg::S_C_FREE: begin
        if (c_hit) begin
          if (ckey_rd == mclm_pkg::COND_FREE) begin
            fresh_d = 1'b0;
            state_d = mclm_pkg::S_C_CHECK;
          end else begin
            cptr_d = cptr_q + 1'b1;
          end
        end else if (c_used_q < mclm_pkg::CCNT_W'(mclm_pkg::CONDITION_SLOTS)) begin
          fresh_d = 1'b1;
          state_d = mclm_pkg::S_REL;
        end else begin
          status_d = mclm_pkg::ST_FULL;
          state_d  = mclm_pkg::S_REPLY;
        end
      end
      mclm_pkg::S_C_CHECK: begin
        if (ccnt_rd >= mclm_pkg::WCNT_W'(mclm_pkg::PROCESS_COUNT)) begin
          status_d = mclm_pkg::ST_FULL;
          state_d  = mclm_pkg::S_REPLY;
        end else begin
          state_d = mclm_pkg::S_REL;
        end
      end
      mclm_pkg::S_C_COMMIT: begin
        cw_we   = 1'b1;
        ckey_we = 1'b1;
        ccnt_we = 1'b1;
        ccnt_wd = (fresh_q ? '0 : ccnt_rd) + 1'b1;
        if (fresh_q) begin
          c_used_d = c_used_q + 1'b1;
        end
        status_d = mclm_pkg::ST_BUSY;
        state_d  = mclm_pkg::S_REPLY;
      end
      mclm_pkg::S_B_SCAN: begin
        if (c_hit) begin
          if (ckey_rd == {1'b0, cid_q}) begin
            j_d     = '0;
            state_d = mclm_pkg::S_B_RD;
          end else begin
            cptr_d = cptr_q + 1'b1;
          end
        end else begin
          state_d = mclm_pkg::S_REPLY;
        end
      end
      mclm_pkg::S_B_RD: begin
        if (j_q < ccnt_rd) begin
          state_d = mclm_pkg::S_B_LD;
        end else begin
          ccnt_we = 1'b1;
          ckey_we = 1'b1;
          ckey_wd = mclm_pkg::COND_FREE;
          cptr_d  = cptr_q + 1'b1;
          state_d = mclm_pkg::S_B_SCAN;
        end
      end
      mclm_pkg::S_B_LD: begin
        lk_pid_d = cw_rdata[mclm_pkg::CWAIT_W-1 -: PW];
        lk_key_d = cw_rdata[IW-1:0];
        mptr_d   = '0;
        state_d  = mclm_pkg::S_L_FIND;
      end
      mclm_pkg::S_B_WAKE: begin
        if (can_emit) begin
          out_valid_d          = 1'b1;
          out_d.kind           = mclm_pkg::KIND_WAKE;
          out_d.status         = mclm_pkg::ST_OK;
          out_d.target_process = lk_pid_q;
          out_d.granted_mutex  = lk_key_q;
          out_d.last_result    = 1'b0;
          j_d     = j_q + 1'b1;
          state_d = mclm_pkg::S_B_RD;
        end
      end
      mclm_pkg::S_REPLY: begin
        if (can_emit) begin
          out_valid_d          = 1'b1;
          out_d.kind           = mclm_pkg::KIND_REPLY;
          out_d.status         = status_q;
          out_d.target_process = pid_q;
          out_d.granted_mutex  = '0;
          out_d.last_result    = 1'b1;
          state_d = mclm_pkg::S_IDLE;
        end
      end
      default: state_d = mclm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mclm_pkg::S_IDLE;
      m_used_q    <= '0;
      c_used_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      m_used_q    <= m_used_d;
      c_used_q    <= c_used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    status_q <= status_d;
    lk_st_q  <= lk_st_d;
    pid_q    <= pid_d;
    mid_q    <= mid_d;
    cid_q    <= cid_d;
    lk_pid_q <= lk_pid_d;
    lk_key_q <= lk_key_d;
    mptr_q   <= mptr_d;
    cptr_q   <= cptr_d;
    j_q      <= j_d;
    fresh_q  <= fresh_d;
    out_q    <= out_d;
    if (key_we)   m_key_q[mi]   <= key_wd;
    if (owner_we) m_owner_q[mi] <= owner_wd;
    if (head_we)  m_head_q[mi]  <= head_wd;
    if (tail_we)  m_tail_q[mi]  <= tail_wd;
    if (ckey_we)  c_key_q[ci]   <= ckey_wd;
    if (ccnt_we)  c_cnt_q[ci]   <= ccnt_wd;
  end

  `MCLM_ASSERT_IMP(a_mutex_used_max, 1'b1, m_used_q <= mclm_pkg::MCNT_W'(mclm_pkg::MUTEX_SLOTS))
  `MCLM_ASSERT_IMP(a_cond_used_max, 1'b1, c_used_q <= mclm_pkg::CCNT_W'(mclm_pkg::CONDITION_SLOTS))
  `MCLM_ASSERT_NXT(a_accept_busy, in_valid_i && in_ready_o, state_q != mclm_pkg::S_IDLE)
  `MCLM_ASSERT_NXT(a_reply_last, state_q == mclm_pkg::S_REPLY && can_emit, out_valid_q && out_q.last_result && state_q == mclm_pkg::S_IDLE)
  `MCLM_ASSERT_IMP(a_wake_not_last, out_valid_q && out_q.kind == mclm_pkg::KIND_WAKE, !out_q.last_result)

endmodule
`default_nettype wire
